### hdl/dhc_pkg.sv
package dhc_pkg;

  localparam int DEPTH_W = 13;
  localparam int LEVEL_W = 8;
  localparam int LEVEL_SCALE = 256;
  localparam int LEVEL_MAX = 255;

  typedef enum logic [0:0] {
    ACT_COUNT = 1'b0,
    ACT_MAP   = 1'b1
  } action_t;

  typedef struct packed {
    logic               action;
    logic [DEPTH_W-1:0] depth;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               last_out;
  } out_word_t;

endpackage

### hdl/depth_histogram_colorizer.sv
// Depth histogram colorizer. A counting pass (action 0) takes one pixel per
// cycle while the output register is not stalled, into a bin memory with one
// read and one write port, read-modify-write and forwarding between
// back-to-back pixels of the same bin. The pixel with last closes the pass:
// a sweep walks every bin, keeps the running sum and divides with a
// bit-serial divider; no word is accepted until the sweep is done. A
// counting pixel after a mapping pass starts a clearing sweep over every
// bin first; after reset the same clearing sweep runs once. A mapping pixel
// (action 1) reads its level from the memory and returns one word through
// an output register; no new word is taken while its read is in flight,
// nor while the output stalls.
module depth_histogram_colorizer import dhc_pkg::*; #(
  parameter int DEPTH_BINS       = 8192,
  parameter int MAX_FRAME_PIXELS = 524288
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int ADDR_W = $clog2(DEPTH_BINS);
  localparam int CNT_W  = $clog2(MAX_FRAME_PIXELS);
  localparam int CUM_W  = CNT_W + 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_RUN   = 5'b00010,
    S_SREAD = 5'b00100,
    S_SDIV  = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

  state_t state;

  logic [CNT_W-1:0]  mem [DEPTH_BINS];
  logic [CNT_W-1:0]  rd_data;
  logic [ADDR_W-1:0] rd_addr, wr_addr, sweep;
  logic [CNT_W-1:0]  wr_data;
  logic              wr_en;

  logic [CNT_W-1:0]  total;
  logic [CUM_W-1:0]  cum, cum_add;
  logic              mapping;

  // stage one: the word whose memory read is in flight
  logic              p_valid, p_count, p_inc, p_map_ok, p_last;
  logic [ADDR_W-1:0] p_addr;
  // last write, for forwarding into stage one
  logic              fw_valid;
  logic [ADDR_W-1:0] fw_addr;
  logic [CNT_W-1:0]  fw_data;

  logic [CNT_W-1:0]  cur;
  logic              in_fire, cnt_fire, depth_ok, cnt_ok, skid_full;
  logic [ADDR_W-1:0] w_addr;
  in_word_t          w;

  logic              d_start;
  logic              d_done;
  logic [LEVEL_W-1:0] d_level;
  logic [CNT_W-1:0]  d_remain;

  assign w       = in_data;
  assign w_addr  = ADDR_W'(w.depth);
  assign depth_ok = ({{(32-DEPTH_W){1'b0}}, w.depth} < DEPTH_BINS) && (w.depth != '0);
  assign skid_full = out_valid && !out_ready;
  // a counting word after the table needs a clear first
  assign in_ready = (state == S_RUN) && !skid_full &&
                    !(p_valid && p_count && p_last) &&
                    !(p_valid && !p_count) &&
                    !(w.action == ACT_COUNT && mapping);
  assign in_fire = in_valid && in_ready;
  assign cnt_fire = in_fire && (w.action == ACT_COUNT) && depth_ok && cnt_ok;

  assign cur = (fw_valid && fw_addr == p_addr) ? fw_data : rd_data;
  assign cnt_ok = ({{(32-CNT_W){1'b0}}, total} < MAX_FRAME_PIXELS - 1);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    rd_addr = in_fire ? w_addr : sweep;
    wr_en   = 1'b0;
    wr_addr = sweep;
    wr_data = '0;
    case (state)
      S_CLEAR: wr_en = 1'b1;
      S_RUN: begin
        if (p_valid && p_inc) begin
          wr_en   = 1'b1;
          wr_addr = p_addr;
          wr_data = cur + 1'b1;
        end
      end
      S_SDIV: begin
        // fetch the next bin while this one divides
        rd_addr = sweep + 1'b1;
        wr_en   = d_done;
        // bin 0 and an empty frame stay dark
        if (sweep != '0 && total != '0) begin
          wr_data = {{(CNT_W-LEVEL_W){1'b0}}, d_level};
        end
      end
      default: ;
    endcase
  end

  // remaining = total - cumulative, with this bin included
  assign cum_add  = cum + {1'b0, rd_data};
  assign d_remain = total - cum_add[CNT_W-1:0];
  assign d_start  = (state == S_SREAD);

  dhc_divider #(.CNT_W(CNT_W)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (d_start),
    .remain (d_remain),
    .total  (total),
    .done   (d_done),
    .level  (d_level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      sweep     <= '0;
      total     <= '0;
      mapping   <= 1'b0;
      p_valid   <= 1'b0;
      fw_valid  <= 1'b0;
      out_valid <= 1'b0;
      cum       <= '0;
    end else begin
      fw_valid <= wr_en;
      fw_addr  <= wr_addr;
      fw_data  <= wr_data;
      p_valid  <= in_fire;
      if (in_fire) begin
        p_addr   <= w_addr;
        p_last   <= w.last;
        p_count  <= (w.action == ACT_COUNT);
        p_inc    <= (w.action == ACT_COUNT) && depth_ok && cnt_ok;
        p_map_ok <= mapping && depth_ok;
      end
      if (p_valid && !p_count) begin
        out_valid <= 1'b1;
        out_data  <= {(p_map_ok ? cur[LEVEL_W-1:0] : LEVEL_W'(0)), p_last};
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (sweep == ADDR_W'(DEPTH_BINS - 1)) begin
            state <= S_RUN;
            sweep <= '0;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_RUN: begin
          if (p_valid && p_count && p_last) begin
            state <= S_DRAIN;
            sweep <= '0;
            cum   <= '0;
          end else if (in_valid && w.action == ACT_COUNT && mapping && !p_valid) begin
            mapping <= 1'b0;
            total   <= '0;
            state   <= S_CLEAR;
            sweep   <= '0;
          end else if (cnt_fire) begin
            total <= total + 1'b1;
          end
        end
        S_DRAIN: state <= S_SREAD;  // let the last count write land
        S_SREAD: begin              // rd_data now holds bin[sweep]
          cum   <= cum_add;
          state <= S_SDIV;
        end
        S_SDIV: begin
          if (d_done) begin
            if (sweep == ADDR_W'(DEPTH_BINS - 1)) begin
              state   <= S_RUN;
              mapping <= 1'b1;
              sweep   <= '0;
            end else begin
              sweep <= sweep + 1'b1;
              state <= S_SREAD;
            end
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state));

  a_ready_in_run: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_RUN);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data));

  a_map_blocks: assert property (@(posedge clk) disable iff (rst)
    p_valid && !p_count |-> !in_ready);

endmodule

### hdl/dhc_divider.sv
module dhc_divider import dhc_pkg::*; #(
  parameter int CNT_W = 19
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [CNT_W-1:0]   remain,
  input  logic [CNT_W-1:0]   total,
  output logic               done,
  output logic [LEVEL_W-1:0] level
);

  // restoring division of 256*remain by total, one quotient bit per cycle
  localparam int QW = CNT_W + LEVEL_W + 1;
  localparam int STEP_W = $clog2(QW + 1);

  logic [QW-1:0]     quot;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvsr;
  logic [STEP_W-1:0] step;
  logic              run;
  logic [CNT_W+1:0]  trial;
  logic [CNT_W:0]    rem_sh;

  assign rem_sh = {rem, quot[QW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= !start && run && (step == STEP_W'(1));
      if (start) begin
        run  <= 1'b1;
        step <= STEP_W'(QW);
        quot <= {1'b0, remain, {LEVEL_W{1'b0}}};
        rem  <= '0;
        dvsr <= total;
      end else if (run) begin
        if (trial[CNT_W+1]) begin
          rem  <= rem_sh[CNT_W-1:0];
          quot <= {quot[QW-2:0], 1'b0};
        end else begin
          rem  <= trial[CNT_W-1:0];
          quot <= {quot[QW-2:0], 1'b1};
        end
        step <= step - 1'b1;
        if (step == STEP_W'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (quot > QW'(LEVEL_MAX)) level = LEVEL_W'(LEVEL_MAX);
    else level = quot[LEVEL_W-1:0];
  end

endmodule

### verif/depth_histogram_colorizer_tb.sv
`timescale 1ns / 1ps

module depth_histogram_colorizer_tb;
  import dhc_pkg::*;

  localparam int NUM_BINS   = 8192;
  localparam int PIX_CAP    = 524288 - 1;
  localparam longint LIMIT  = 6_000_000;

  class level_scoreboard;
    int unsigned bin_count [NUM_BINS];
    int unsigned pixel_total;
    bit          table_ready;
    out_word_t   pending_levels [$];
    int          errors;

    function new();
      foreach (bin_count[i]) bin_count[i] = 0;
      pixel_total = 0;
      table_ready = 0;
      errors = 0;
    endfunction

    // turn counts into levels once the counting pass closes
    function void build_levels();
      longint unsigned cum;
      longint unsigned lvl;
      cum = 0;
      for (int i = 0; i < NUM_BINS; i++) begin
        cum += bin_count[i];
        lvl = 0;
        if (i != 0 && pixel_total != 0 && cum <= pixel_total) begin
          lvl = (longint'(LEVEL_SCALE) * (pixel_total - cum)) / pixel_total;
          if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
        end
        bin_count[i] = int'(lvl);
      end
      table_ready = 1;
    endfunction

    function void note_word(in_word_t w);
      out_word_t r;
      if (w.action == ACT_COUNT) begin
        if (table_ready) begin
          foreach (bin_count[i]) bin_count[i] = 0;
          pixel_total = 0;
          table_ready = 0;
        end
        if (w.depth != 0 && pixel_total < PIX_CAP) begin
          bin_count[w.depth]++;
          pixel_total++;
        end
        if (w.last) build_levels();
      end else begin
        r.level = table_ready ? bin_count[w.depth][LEVEL_W-1:0] : '0;
        r.last_out = w.last;
        pending_levels = {pending_levels, r};
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (pending_levels.size() == 0) begin
        $error("unexpected word: level %0d last_out %0d", got.level, got.last_out);
        errors++;
        return;
      end
      exp_w = pending_levels.pop_front();
      if (got.level !== exp_w.level) begin
        $error("level: expected %0d, got %0d", exp_w.level, got.level);
        errors++;
      end
      if (got.last_out !== exp_w.last_out) begin
        $error("last_out: expected %0d, got %0d", exp_w.last_out, got.last_out);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_word_t out_data;

  level_scoreboard sb = new();
  longint    cycles = 0;
  int        burst_left = 0;
  int        clus_base = 1;
  int        clus_span = 4;

  always #5 clk = ~clk;

  depth_histogram_colorizer i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_word(out_data);
  end

  // receiver stall pattern: stretches of always ready, random, and long stalls
  int stall_mode = 0;
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(5, 60);
    end
    stall_left--;
    case (stall_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_ready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  task automatic send_word(input logic act, input logic [DEPTH_W-1:0] d, input logic l);
    in_word_t w;
    int gap;
    w.action = act;
    w.depth = d;
    w.last = l;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
    @(negedge clk);
  endtask

  task automatic drain_levels();
    in_valid <= 1'b0;
    while (sb.pending_levels.size() != 0) @(negedge clk);
  endtask

  // counting pass over a cluster of depths, with zeros and full-range noise
  task automatic count_frame(input int n);
    logic [DEPTH_W-1:0] d;
    clus_base = $urandom_range(1, 8000);
    clus_span = $urandom_range(4, 150);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: d = '0;
        1: d = DEPTH_W'($urandom_range(0, 8191));
        default: d = DEPTH_W'(clus_base + $urandom_range(0, clus_span));
      endcase
      send_word(ACT_COUNT, d, i == n - 1);
    end
  endtask

  // mapping pass mostly over the last cluster, some full-range depths
  task automatic map_frame(input int n);
    logic [DEPTH_W-1:0] d;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) d = DEPTH_W'($urandom_range(0, 8191));
      else d = DEPTH_W'(clus_base + $urandom_range(0, clus_span));
      send_word(ACT_MAP, d, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // map before any table: always level 0
    send_word(ACT_MAP, 13'd0, 1'b0);
    send_word(ACT_MAP, 13'd8191, 1'b1);
    send_word(ACT_MAP, 13'd5, 1'b0);

    // small frame with extreme depths and a zero
    send_word(ACT_COUNT, 13'd0, 1'b0);
    send_word(ACT_COUNT, 13'd1, 1'b0);
    send_word(ACT_COUNT, 13'd1, 1'b0);
    send_word(ACT_COUNT, 13'd100, 1'b0);
    send_word(ACT_COUNT, 13'd4096, 1'b0);
    send_word(ACT_COUNT, 13'd8191, 1'b1);
    send_word(ACT_MAP, 13'd0, 1'b0);
    send_word(ACT_MAP, 13'd1, 1'b0);
    send_word(ACT_MAP, 13'd2, 1'b0);
    send_word(ACT_MAP, 13'd100, 1'b1);
    send_word(ACT_MAP, 13'd4096, 1'b0);
    send_word(ACT_MAP, 13'd8191, 1'b1);
    // repeated mapping pass keeps the table
    send_word(ACT_MAP, 13'd1, 1'b1);
    send_word(ACT_MAP, 13'd8191, 1'b0);

    // hold off until every level is back, then an empty frame
    drain_levels();
    send_word(ACT_COUNT, 13'd0, 1'b0);
    send_word(ACT_COUNT, 13'd0, 1'b1);
    send_word(ACT_MAP, 13'd0, 1'b0);
    send_word(ACT_MAP, 13'd1, 1'b1);
    send_word(ACT_MAP, 13'd8191, 1'b0);

    for (int f = 0; f < 2; f++) begin
      count_frame(250);
      map_frame(330);
    end

    drain_levels();
    repeat (50) @(negedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
